// ===== src/htn_pkg.sv =====
// ----------------------------------------------------------------------------
// htn_pkg
// Types and constants shared by the height-map-to-normal datapath.
// ----------------------------------------------------------------------------
package htn_pkg;

    localparam int SIDE_W   = 13;
    localparam int MAX_SIDE = 4096;
    localparam int M_W      = 29;   // scaled slope magnitude
    localparam int SUM_W    = 58;   // sum of squares
    localparam int REM_W    = 31;   // square root remainder
    localparam int DEN_W    = 30;   // twice the length
    localparam int NUM_W    = 46;   // rounded dividend
    localparam int Q_W      = 16;
    localparam int LANES    = 3;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [15:0]    BORDER_COMP = 16'd18919;
    localparam logic [M_W-1:0] MY_VAL      = M_W'(32'h0002_0000);
    localparam logic [Q_W-1:0] Q_SAT       = 16'd32767;

    typedef struct packed {
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [15:0] h_center;
        logic [15:0] h_up;
        logic [15:0] h_right;
        logic [15:0] h_down;
        logic [15:0] h_left;
    } t_in;

    typedef struct packed {
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [15:0]        height_out;
    } t_out;

    typedef struct packed {
        logic [SUM_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [M_W-1:0]   root;
    } t_sq;

    typedef struct packed {
        logic           border;
        logic           negx;
        logic           negz;
        logic [M_W-1:0] mx;
        logic [M_W-1:0] mz;
        logic [15:0]    hc;
    } t_side;

    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0] num;
        logic [DEN_W-1:0]            den;
        logic [LANES-1:0][Q_W-1:0]   q;
    } t_dv;

    typedef struct packed {
        logic        border;
        logic        negx;
        logic        negz;
        logic [15:0] hc;
    } t_dside;

endpackage

// ===== src/htn_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// htn_sqrt_cell
// One root bit of the digit-by-digit square root, registered.
// ----------------------------------------------------------------------------
module htn_sqrt_cell #(
    parameter int K = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  htn_pkg::t_sq   i_sq,
    input  htn_pkg::t_side i_side,
    output logic           o_vld,
    output htn_pkg::t_sq   o_sq,
    output htn_pkg::t_side o_side
);
    import htn_pkg::*;

    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;
    t_sq              n_sq;

    always_comb begin
        cur       = {i_sq.rem, i_sq.rad[2*K+1 -: 2]};
        trial     = {2'b00, i_sq.root, 2'b01};
        ge        = (cur >= trial);
        diff      = cur - trial;
        n_sq.rad  = i_sq.rad;
        n_sq.rem  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        n_sq.root = {i_sq.root[M_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_sq   <= n_sq;
        o_side <= i_side;
    end

endmodule

// ===== src/htn_div_cell.sv =====
// ----------------------------------------------------------------------------
// htn_div_cell
// One quotient bit of three parallel restoring divisions, registered.
// ----------------------------------------------------------------------------
module htn_div_cell #(
    parameter int K = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  htn_pkg::t_dv    i_dv,
    input  htn_pkg::t_dside i_side,
    output logic            o_vld,
    output htn_pkg::t_dv    o_dv,
    output htn_pkg::t_dside o_side
);
    import htn_pkg::*;

    logic [NUM_W-1:0] sh;
    t_dv              n_dv;

    always_comb begin
        sh   = NUM_W'(i_dv.den) << K;
        n_dv = i_dv;
        for (int l = 0; l < LANES; l++) begin
            if (i_dv.num[l] >= sh) begin
                n_dv.num[l]  = i_dv.num[l] - sh;
                n_dv.q[l][K] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_dv   <= n_dv;
        o_side <= i_side;
    end

endmodule

// ===== src/height_to_normal_map.sv =====
// A result strobes after stages 0 to 3, both chains and the output register.
// Throughput: one pixel per cycle; busy is always low and pixels overlap freely.
// The chains: 29 square root cells, then the dividend register, then 16 divider cells.
// Synchronous active-low reset clears the valid chain and sets both sides to 1024.
// The receiver cannot stall, so results are never held.
// ----------------------------------------------------------------------------
// height_to_normal_map
// Central-difference surface normal of a height map pixel, Q1.15 output.
// ----------------------------------------------------------------------------
module height_to_normal_map (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  htn_pkg::t_in         i_pixel,
    output logic                 o_strobe,
    output htn_pkg::t_out        o_normal,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [12:0]          i_cfg_data
);
    import htn_pkg::*;

    localparam int SQ_N  = M_W;
    localparam int DIV_N = Q_W;

    logic [SIDE_W-1:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIDE_W'(1024);
            r_height <= SIDE_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 0: input register.
    logic r_v0;
    t_in  r_in;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
        r_in <= i_pixel;
    end

    // Stage 1: differences, interior test and slope scaling.
    logic [SIDE_W-1:0] w_lim, h_lim;
    logic [15:0]       dx, dz;
    logic              negx, negz, border;
    always_comb begin
        w_lim  = (r_width  > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : r_width;
        h_lim  = (r_height > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : r_height;
        negx   = r_in.h_left < r_in.h_right;
        negz   = r_in.h_up < r_in.h_down;
        dx     = negx ? r_in.h_right - r_in.h_left : r_in.h_left - r_in.h_right;
        dz     = negz ? r_in.h_down - r_in.h_up : r_in.h_up - r_in.h_down;
        border = !((r_in.pos_x != 12'd0) && (r_in.pos_y != 12'd0)
                 && ({1'b0, r_in.pos_x} + 13'd1 < w_lim)
                 && ({1'b0, r_in.pos_y} + 13'd1 < h_lim));
    end

    logic  r_v1;
    t_side r_s1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
        r_s1.border <= border;
        r_s1.negx   <= negx;
        r_s1.negz   <= negz;
        r_s1.mx     <= M_W'(w_lim * dx);
        r_s1.mz     <= M_W'(h_lim * dz);
        r_s1.hc     <= r_in.h_center;
    end

    // Stage 2: squares.
    logic             r_v2;
    t_side            r_s2;
    logic [SUM_W-1:0] r_sqx, r_sqz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_s2  <= r_s1;
        r_sqx <= SUM_W'(r_s1.mx * r_s1.mx);
        r_sqz <= SUM_W'(r_s1.mz * r_s1.mz);
    end

    // Stage 3: sum of squares, the y term being a constant.
    logic  r_v3;
    t_side r_s3;
    t_sq   r_q3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_s3      <= r_s2;
        r_q3.rad  <= r_sqx + r_sqz + (SUM_W'(1) << 34);
        r_q3.rem  <= '0;
        r_q3.root <= '0;
    end

    // Square root chain, most significant root bit first.
    logic  sq_v [SQ_N+1];
    t_sq   sq_d [SQ_N+1];
    t_side sq_s [SQ_N+1];
    assign sq_v[0] = r_v3;
    assign sq_d[0] = r_q3;
    assign sq_s[0] = r_s3;

    for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
        htn_sqrt_cell #(.K(SQ_N-1-g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (sq_v[g]),
            .i_sq   (sq_d[g]),
            .i_side (sq_s[g]),
            .o_vld  (sq_v[g+1]),
            .o_sq   (sq_d[g+1]),
            .o_side (sq_s[g+1])
        );
    end

    // Rounded dividends m*65536 + len over 2*len.
    logic [M_W-1:0] len;
    assign len = (sq_d[SQ_N].root == '0) ? M_W'(1) : sq_d[SQ_N].root;

    logic   r_vp;
    t_dv    r_dp;
    t_dside r_sp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else begin
            r_vp <= sq_v[SQ_N];
        end
        r_dp.num[0] <= {1'b0, sq_s[SQ_N].mx, 16'd0} + NUM_W'(len);
        r_dp.num[1] <= {1'b0, MY_VAL, 16'd0} + NUM_W'(len);
        r_dp.num[2] <= {1'b0, sq_s[SQ_N].mz, 16'd0} + NUM_W'(len);
        r_dp.den    <= {len, 1'b0};
        r_dp.q      <= '0;
        r_sp.border <= sq_s[SQ_N].border;
        r_sp.negx   <= sq_s[SQ_N].negx;
        r_sp.negz   <= sq_s[SQ_N].negz;
        r_sp.hc     <= sq_s[SQ_N].hc;
    end

    // Divider chain, one quotient bit per cell.
    logic   dv_v [DIV_N+1];
    t_dv    dv_d [DIV_N+1];
    t_dside dv_s [DIV_N+1];
    assign dv_v[0] = r_vp;
    assign dv_d[0] = r_dp;
    assign dv_s[0] = r_sp;

    for (genvar g = 0; g < DIV_N; g++) begin : g_div
        htn_div_cell #(.K(DIV_N-1-g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (dv_v[g]),
            .i_dv   (dv_d[g]),
            .i_side (dv_s[g]),
            .o_vld  (dv_v[g+1]),
            .o_dv   (dv_d[g+1]),
            .o_side (dv_s[g+1])
        );
    end

    // Sign and saturation; a positive quotient of 32768 clips.
    logic [LANES-1:0]          lane_neg;
    logic [LANES-1:0][Q_W-1:0] comp;
    t_out                      n_out;
    always_comb begin
        lane_neg = {dv_s[DIV_N].negz, 1'b0, dv_s[DIV_N].negx};
        for (int l = 0; l < LANES; l++) begin
            if (lane_neg[l]) begin
                comp[l] = Q_W'(17'h10000 - {1'b0, dv_d[DIV_N].q[l]});
            end else begin
                comp[l] = (dv_d[DIV_N].q[l] > Q_SAT) ? Q_SAT : dv_d[DIV_N].q[l];
            end
        end
        if (dv_s[DIV_N].border) begin
            n_out.norm_x = BORDER_COMP;
            n_out.norm_y = BORDER_COMP;
            n_out.norm_z = BORDER_COMP;
        end else begin
            n_out.norm_x = comp[0];
            n_out.norm_y = comp[1];
            n_out.norm_z = comp[2];
        end
        n_out.height_out = dv_s[DIV_N].hc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= dv_v[DIV_N];
        end
        o_normal <= n_out;
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives height-map pixels into height_to_normal_map under random idle gaps
// and compares every returned normal with a fixed-point normal calculator.
// ----------------------------------------------------------------------------
module testbench;

    import htn_pkg::*;

    localparam int LATENCY    = 51;
    localparam int STALL_LIMIT = 20000;
    localparam int N_RANDOM   = 1800;
    localparam int N_DIRECTED = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in         i_pixel = '0;
    logic        o_strobe;
    t_out        o_normal;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [12:0] i_cfg_data = '0;

    height_to_normal_map i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pixel    (i_pixel),
        .o_strobe   (o_strobe),
        .o_normal   (o_normal),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    logic [12:0] side_w = 13'd1024;
    logic [12:0] side_h = 13'd1024;
    t_out        normals_due[$];
    int          n_errors = 0;
    int          idle_count = 0;
    bit          idle_on = 1'b1;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] unit_comp(longint unsigned m, bit neg,
                                              longint unsigned len);
        longint unsigned q;
        q = (m * 65536 + len) / (2 * len);
        if (neg) return 16'(64'h10000 - q);
        if (q > 32767) q = 32767;
        return 16'(q);
    endfunction

    function automatic t_out surface_normal(t_in px);
        t_out            r;
        longint unsigned w, h, dx, dz, mx, my, mz, len;
        bit              negx, negz;
        w = (side_w > MAX_SIDE) ? MAX_SIDE : side_w;
        h = (side_h > MAX_SIDE) ? MAX_SIDE : side_h;
        r.height_out = px.h_center;
        if (!(px.pos_x > 0 && px.pos_y > 0 && px.pos_x + 1 < w && px.pos_y + 1 < h)) begin
            r.norm_x = BORDER_COMP;
            r.norm_y = BORDER_COMP;
            r.norm_z = BORDER_COMP;
            return r;
        end
        negx = px.h_left < px.h_right;
        negz = px.h_up < px.h_down;
        dx = negx ? px.h_right - px.h_left : px.h_left - px.h_right;
        dz = negz ? px.h_down - px.h_up : px.h_up - px.h_down;
        mx = w * dx;
        my = 64'd2 << 16;
        mz = h * dz;
        len = isqrt(mx * mx + my * my + mz * mz);
        if (len == 0) len = 1;
        r.norm_x = unit_comp(mx, negx && mx != 0, len);
        r.norm_y = unit_comp(my, 1'b0, len);
        r.norm_z = unit_comp(mz, negz && mz != 0, len);
        return r;
    endfunction

    // Result checker; the receiver cannot stall, so every strobe is a beat.
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_strobe) begin
            if (normals_due.size() == 0) begin
                $error("unexpected normal beat");
                n_errors++;
            end else begin
                e = normals_due.pop_front();
                if (o_normal.norm_x !== e.norm_x) begin
                    $error("norm_x exp %0d got %0d", e.norm_x, o_normal.norm_x);
                    n_errors++;
                end
                if (o_normal.norm_y !== e.norm_y) begin
                    $error("norm_y exp %0d got %0d", e.norm_y, o_normal.norm_y);
                    n_errors++;
                end
                if (o_normal.norm_z !== e.norm_z) begin
                    $error("norm_z exp %0d got %0d", e.norm_z, o_normal.norm_z);
                    n_errors++;
                end
                if (o_normal.height_out !== e.height_out) begin
                    $error("height_out exp %0h got %0h", e.height_out,
                           o_normal.height_out);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any beat in either direction.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input bit idx, input logic [12:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_WIDTH) side_w = val;
        else side_h = val;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (normals_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Sends one pixel; start stays high across back-to-back beats, and the
    // caller lowers it once the last pixel is out.
    task automatic send_pixel(input t_in px, input bit with_gaps);
        while (with_gaps && idle_on && $urandom_range(99) < 35) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_pixel <= px;
        normals_due.push_back(surface_normal(px));
        do @(posedge i_clk); while (busy);
    endtask

    function automatic t_in make_pixel(bit tame);
        t_in p;
        p = t_in'(104'({$urandom, $urandom, $urandom, $urandom}));
        if (tame) begin
            p.pos_x = 12'($urandom_range(side_w > 1 ? side_w : 1));
            p.pos_y = 12'($urandom_range(side_h > 1 ? side_h : 1));
        end
        return p;
    endfunction

    t_in  dir_px [N_DIRECTED];
    t_out dir_exp[N_DIRECTED];
    bit   dir_typed[N_DIRECTED];

    initial begin
        t_out border_n;
        t_in  p;
        border_n = '{BORDER_COMP, BORDER_COMP, BORDER_COMP, 16'h0};
        // Columns: x, y, centre, up, right, down, left.
        dir_px[0]  = '{12'd0, 12'd5, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0};
        dir_px[1]  = '{12'd5, 12'd0, 16'h0000, 16'h1, 16'h2, 16'h3, 16'h4};
        dir_px[2]  = '{12'd1023, 12'd5, 16'h1234, 16'hFFFF, 16'h0, 16'h0, 16'hFFFF};
        dir_px[3]  = '{12'd5, 12'd1023, 16'h4321, 16'h0, 16'h0, 16'h0, 16'h0};
        dir_px[4]  = '{12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        dir_px[5]  = '{12'd1, 12'd1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0};
        dir_px[6]  = '{12'd1022, 12'd1022, 16'hAAAA, 16'h0, 16'hFFFF, 16'hFFFF, 16'h0};
        dir_px[7]  = '{12'd100, 12'd200, 16'h5555, 16'hFFFF, 16'h0, 16'h0, 16'hFFFF};
        dir_px[8]  = '{12'd2, 12'd3, 16'h8000, 16'h8000, 16'h8001, 16'h8001, 16'h8000};
        dir_px[9]  = '{12'd500, 12'd500, 16'h7FFF, 16'h0001, 16'h0, 16'h0, 16'h0001};
        dir_px[10] = '{12'd7, 12'd9, 16'h00FF, 16'h1000, 16'h2000, 16'h3000, 16'h4000};
        dir_px[11] = '{12'd1000, 12'd10, 16'hF0F0, 16'h0, 16'h0, 16'h0, 16'h0};
        for (int k = 0; k < N_DIRECTED; k++) dir_typed[k] = (k < 5) || (k == 5);
        for (int k = 0; k < 5; k++) begin
            dir_exp[k] = border_n;
            dir_exp[k].height_out = dir_px[k].h_center;
        end
        // Flat interior pixel points straight up.
        dir_exp[5] = '{16'sd0, 16'sd32767, 16'sd0, 16'h0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) begin
            send_pixel(dir_px[k], 1'b0);
            if (dir_typed[k] && normals_due[$] !== dir_exp[k]) begin
                $error("calculator disagrees with table row %0d", k);
                n_errors++;
            end
        end
        drain();

        // Register extremes, including values beyond the maximum side and zero.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_WIDTH, 13'd4096); write_reg(CFG_HEIGHT, 13'd4096); end
                1: begin write_reg(CFG_WIDTH, 13'h1FFF); write_reg(CFG_HEIGHT, 13'd3); end
                2: begin write_reg(CFG_WIDTH, 13'd0); write_reg(CFG_HEIGHT, 13'd1); end
                3: begin write_reg(CFG_WIDTH, 13'd3); write_reg(CFG_HEIGHT, 13'h1FFF); end
                4: begin write_reg(CFG_WIDTH, 13'($urandom_range(3, 4096)));
                         write_reg(CFG_HEIGHT, 13'($urandom_range(3, 4096))); end
                default: begin write_reg(CFG_WIDTH, 13'd64); write_reg(CFG_HEIGHT, 13'd48); end
            endcase
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                // A burst without gaps in the middle of each phase.
                idle_on = !(n >= 100 && n < 160);
                p = make_pixel($urandom_range(99) < 80);
                send_pixel(p, 1'b1);
            end
            idle_on = 1'b1;
            drain();
        end

        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
